>>> design/eac_pkg.sv
// Shared types, constants and the arctangent table for the elliptic arc to Bezier block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package eac_pkg;

	// coordinate and angle formats
	localparam int COORD_W      = 24;
	localparam int RAD_W        = COORD_W - 1;
	localparam int ANGLE_STEPS  = 64;
	localparam int QUARTER      = 90 * ANGLE_STEPS;
	localparam int FULL_TURN    = 4 * QUARTER;
	localparam int FINE_SCALE   = 65536 / ANGLE_STEPS;
	localparam int FINE_QUARTER = 90 * 65536;
	localparam int FINE_W       = 25;
	localparam int MAX_PIECES   = 5;

	// trig unit formats
	localparam int TRIG_W       = 18;
	localparam int TRIG_ONE     = 65536;
	localparam int XY_W         = 34;
	localparam int Z_W          = 25;
	localparam int CORDIC_K     = 652032875;
	localparam int CORDIC_STEPS = 18;

	// divider and root formats
	localparam int DIV_NUM_W    = 49;
	localparam int DIV_DEN_W    = 33;
	localparam int DIV_Q_W      = 20;
	localparam int SQRT_OP_W    = 38;
	localparam int SQRT_W       = SQRT_OP_W / 2;

	// ceil(2^22 / 3): (v * DIV3_MAGIC) >> DIV3_SHIFT is floor(v / 3) for v below 2^21
	localparam int DIV3_MAGIC   = 1398102;
	localparam int DIV3_SHIFT   = 22;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic [RAD_W-1:0]          radius_x;
		logic [RAD_W-1:0]          radius_y;
		logic [15:0]               start_angle;
		logic [14:0]               span_angle;
		logic                      counter_clockwise;
		logic [15:0]               first_segment_id;
	} arc_req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] ctrl1_x;
		logic signed [COORD_W-1:0] ctrl1_y;
		logic signed [COORD_W-1:0] ctrl2_x;
		logic signed [COORD_W-1:0] ctrl2_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic [15:0]               segment_id;
		logic                      last_piece;
	} seg_res_t;

	// atan(2^-i) in degrees times 65536
	function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			5'd0:  v = 25'sd2949120;
			5'd1:  v = 25'sd1740967;
			5'd2:  v = 25'sd919879;
			5'd3:  v = 25'sd466945;
			5'd4:  v = 25'sd234379;
			5'd5:  v = 25'sd117304;
			5'd6:  v = 25'sd58666;
			5'd7:  v = 25'sd29335;
			5'd8:  v = 25'sd14668;
			5'd9:  v = 25'sd7334;
			5'd10: v = 25'sd3667;
			5'd11: v = 25'sd1833;
			5'd12: v = 25'sd917;
			5'd13: v = 25'sd458;
			5'd14: v = 25'sd229;
			5'd15: v = 25'sd115;
			5'd16: v = 25'sd57;
			5'd17: v = 25'sd29;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> design/eac_cordic.sv
// Iterative CORDIC giving Q1.16 cosine and sine of an angle in degrees times 65536.
// Depends on eac_pkg; one rotation step per cycle.
`timescale 1ns / 1ps

module eac_cordic import eac_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [FINE_W-1:0]        angle,
	output logic                     done,
	output logic signed [TRIG_W-1:0] cos_v,
	output logic signed [TRIG_W-1:0] sin_v
);

	logic                   busy_q;
	logic                   done_q;
	logic [4:0]             step_q;
	logic [1:0]             quad_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;

	logic [1:0]             quad_w;
	logic [FINE_W-1:0]      base_w;
	logic signed [XY_W-1:0] dx_w;
	logic signed [XY_W-1:0] dy_w;
	logic signed [19:0]     xr_w;
	logic signed [19:0]     yr_w;
	logic [16:0]            cc_w;
	logic [16:0]            ss_w;

	// quadrant split of the incoming angle
	always_comb begin
		if (angle < FINE_W'(FINE_QUARTER)) begin
			quad_w = 2'd0;
			base_w = '0;
		end else if (angle < FINE_W'(2 * FINE_QUARTER)) begin
			quad_w = 2'd1;
			base_w = FINE_W'(FINE_QUARTER);
		end else if (angle < FINE_W'(3 * FINE_QUARTER)) begin
			quad_w = 2'd2;
			base_w = FINE_W'(2 * FINE_QUARTER);
		end else begin
			quad_w = 2'd3;
			base_w = FINE_W'(3 * FINE_QUARTER);
		end
	end

	assign dx_w = y_q >>> step_q;
	assign dy_w = x_q >>> step_q;

	// rotation steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= quad_w;
			x_q    <= XY_W'(CORDIC_K);
			y_q    <= '0;
			z_q    <= Z_W'(angle - base_w);
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx_w;
				y_q <= y_q + dy_w;
				z_q <= z_q - atan_entry(step_q);
			end else begin
				x_q <= x_q + dx_w;
				y_q <= y_q - dy_w;
				z_q <= z_q + atan_entry(step_q);
			end
		end
	end

	// round to q16, clamp to [0, one], then apply the quadrant
	assign xr_w = 20'((x_q + XY_W'(8192)) >>> 14);
	assign yr_w = 20'((y_q + XY_W'(8192)) >>> 14);

	always_comb begin
		if (xr_w < 0)
			cc_w = '0;
		else if (xr_w > 20'sd65536)
			cc_w = 17'(TRIG_ONE);
		else
			cc_w = xr_w[16:0];
		if (yr_w < 0)
			ss_w = '0;
		else if (yr_w > 20'sd65536)
			ss_w = 17'(TRIG_ONE);
		else
			ss_w = yr_w[16:0];
		case (quad_q)
			2'd0: begin
				cos_v = $signed({1'b0, cc_w});
				sin_v = $signed({1'b0, ss_w});
			end
			2'd1: begin
				cos_v = -$signed({1'b0, ss_w});
				sin_v = $signed({1'b0, cc_w});
			end
			2'd2: begin
				cos_v = -$signed({1'b0, cc_w});
				sin_v = -$signed({1'b0, ss_w});
			end
			default: begin
				cos_v = $signed({1'b0, ss_w});
				sin_v = -$signed({1'b0, cc_w});
			end
		endcase
	end

	assign done = done_q;

endmodule

>>> design/eac_div.sv
// Restoring divider, one quotient bit per cycle, for quotients below 2^20.
// Depends on eac_pkg.
`timescale 1ns / 1ps

module eac_div import eac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_Q_W-1:0]   quo
);

	logic                 busy_q;
	logic                 done_q;
	logic [4:0]           cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_Q_W-1:0]   nb_q;
	logic [DIV_Q_W-1:0]   quo_q;

	logic [DIV_DEN_W:0]   t_w;
	logic [DIV_DEN_W:0]   diff_w;
	logic                 ge_w;

	assign t_w    = {rem_q, nb_q[DIV_Q_W-1]};
	assign ge_w   = t_w >= {1'b0, den_q};
	assign diff_w = t_w - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// high numerator bits start as the remainder, the rest shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
			nb_q  <= num[DIV_Q_W-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge_w ? diff_w[DIV_DEN_W-1:0] : t_w[DIV_DEN_W-1:0];
			nb_q  <= {nb_q[DIV_Q_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_Q_W-2:0], ge_w};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> design/eac_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on eac_pkg.
`timescale 1ns / 1ps

module eac_sqrt import eac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SQRT_OP_W-1:0] op,
	output logic                 done,
	output logic [SQRT_W-1:0]    root
);

	logic                 busy_q;
	logic                 done_q;
	logic [4:0]           cnt_q;
	logic [SQRT_OP_W-1:0] op_q;
	logic [SQRT_W+1:0]    rem_q;
	logic [SQRT_W-1:0]    root_q;

	logic [SQRT_W+3:0]    t_w;
	logic [SQRT_W+3:0]    trial_w;
	logic [SQRT_W+3:0]    diff_w;
	logic                 ge_w;

	assign t_w     = {rem_q, op_q[SQRT_OP_W-1:SQRT_OP_W-2]};
	assign trial_w = (SQRT_W + 4)'({root_q, 2'b01});
	assign ge_w    = t_w >= trial_w;
	assign diff_w  = t_w - trial_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(SQRT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// two operand bits per step
	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= op;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q   <= {op_q[SQRT_OP_W-3:0], 2'b00};
			rem_q  <= ge_w ? diff_w[SQRT_W+1:0] : t_w[SQRT_W+1:0];
			root_q <= {root_q[SQRT_W-2:0], ge_w};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> design/elliptic_arc_to_cubic_bezier.sv
// Converts one elliptical arc into up to five cubic Bezier segments, one per quarter turn.
// Top level; depends on eac_pkg, eac_cordic, eac_div and eac_sqrt.
`timescale 1ns / 1ps

// An arc request is taken only while the block is idle. The arc is cut at quarter-turn
// boundaries and each piece runs through one sequencer pass: a setup state, four CORDIC
// runs (start, end, span, half span), the squares on the single shared multiplier, a
// divide for the squared half-angle tangent, a square root, then the shared multiplier
// again (arm length with a reciprocal-of-three multiply, arm terms and the eight points)
// and an output state. The request port stays low from the moment an arc is taken until
// its last segment has been loaded, including any time in which a finished segment waits
// for the receiver to free the output register. A finished segment sits in that register
// while the next piece is computed; a zero span is taken and produces no segment.
module elliptic_arc_to_cubic_bezier import eac_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     arc_valid,
	output logic     arc_ready,
	input  arc_req_t arc,
	output logic     seg_valid,
	input  logic     seg_ready,
	output seg_res_t seg
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_SETUP = 11'b00000000010,
		ST_TRIG  = 11'b00000000100,
		ST_MULSQ = 11'b00000001000,
		ST_DIV   = 11'b00000010000,
		ST_SQRT  = 11'b00000100000,
		ST_MULA  = 11'b00001000000,
		ST_DIV3  = 11'b00010000000,
		ST_MULF  = 11'b00100000000,
		ST_PLACE = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;

	// arc request fields
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic [RAD_W-1:0]          rx_q;
	logic [RAD_W-1:0]          ry_q;
	logic                      ccw_q;
	logic [15:0]               id_q;

	// piece splitting
	logic [15:0] e_q;
	logic [15:0] prev_q;
	logic [15:0] bnd_q;
	logic        first_q;
	logic [2:0]  n_q;
	logic [15:0] a0_q;
	logic [15:0] a1_q;
	logic [12:0] d_q;
	logic        last_q;

	// sequencing
	logic [1:0] tidx_q;
	logic       launch_q;
	logic [3:0] sub_q;

	// per-piece arithmetic
	logic signed [TRIG_W-1:0] c0_q;
	logic signed [TRIG_W-1:0] s0_q;
	logic signed [TRIG_W-1:0] c1_q;
	logic signed [TRIG_W-1:0] s1_q;
	logic [16:0]              sd_q;
	logic [16:0]              ch_q;
	logic [16:0]              sh_q;
	logic [DIV_DEN_W-1:0]     sq_q;
	logic [DIV_DEN_W-1:0]     cq_q;
	logic [DIV_Q_W-1:0]       t2_q;
	logic [SQRT_W-1:0]        root_q;
	logic [20:0]              v_q;
	logic [DIV_Q_W-1:0]       alpha_q;
	logic signed [19:0]       m_q [4];
	logic signed [COORD_W-1:0] pt_q [8];
	logic signed [49:0]       prod_q;

	seg_res_t seg_q;
	logic     seg_valid_q;

	// shared units
	logic                     cordic_start;
	logic [FINE_W-1:0]        cordic_angle;
	logic                     cordic_done;
	logic signed [TRIG_W-1:0] cordic_cos;
	logic signed [TRIG_W-1:0] cordic_sin;
	logic                     div_start;
	logic [DIV_NUM_W-1:0]     div_num;
	logic [DIV_DEN_W-1:0]     div_den;
	logic                     div_done;
	logic [DIV_Q_W-1:0]       div_quo;
	logic                     sqrt_start;
	logic [SQRT_OP_W-1:0]     sqrt_op;
	logic                     sqrt_done;
	logic [SQRT_W-1:0]        sqrt_root;

	// combinational helpers
	logic [15:0]              s_wrap_w;
	logic [14:0]              span_w;
	logic [15:0]              bnd_w;
	logic [15:0]              a1_w;
	logic                     last_w;
	logic [14:0]              a0_mod_w;
	logic [14:0]              a1_mod_w;
	logic signed [24:0]       mul_a;
	logic signed [24:0]       mul_b;
	logic signed [19:0]       fac [8];
	logic signed [19:0]       m_w;
	logic signed [33:0]       rr_w;
	logic signed [34:0]       sum_w;
	logic signed [COORD_W-1:0] sat_w;
	logic [21:0]              t2x3_w;
	logic                     seg_free;

	eac_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (cordic_angle),
		.done   (cordic_done),
		.cos_v  (cordic_cos),
		.sin_v  (cordic_sin)
	);

	eac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	eac_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.op     (sqrt_op),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// wrap the start angle, saturate the span, find the next quarter boundary
	always_comb begin
		if (arc.start_angle >= 16'(2 * FULL_TURN))
			s_wrap_w = arc.start_angle - 16'(2 * FULL_TURN);
		else if (arc.start_angle >= 16'(FULL_TURN))
			s_wrap_w = arc.start_angle - 16'(FULL_TURN);
		else
			s_wrap_w = arc.start_angle;
		span_w = (arc.span_angle > 15'(FULL_TURN)) ? 15'(FULL_TURN) : arc.span_angle;
		if (s_wrap_w < 16'(QUARTER))
			bnd_w = 16'(QUARTER);
		else if (s_wrap_w < 16'(2 * QUARTER))
			bnd_w = 16'(2 * QUARTER);
		else if (s_wrap_w < 16'(3 * QUARTER))
			bnd_w = 16'(3 * QUARTER);
		else
			bnd_w = 16'(FULL_TURN);
	end

	// end of the current piece
	always_comb begin
		if (first_q)
			a1_w = (e_q < bnd_q) ? e_q : bnd_q;
		else if (e_q - prev_q >= 16'(QUARTER))
			a1_w = prev_q + 16'(QUARTER);
		else
			a1_w = e_q;
		last_w = (n_q == 3'(MAX_PIECES - 1)) || (e_q <= a1_w);
	end

	// trig angle select
	assign a0_mod_w = (a0_q >= 16'(FULL_TURN)) ? 15'(a0_q - 16'(FULL_TURN)) : a0_q[14:0];
	assign a1_mod_w = (a1_q >= 16'(FULL_TURN)) ? 15'(a1_q - 16'(FULL_TURN)) : a1_q[14:0];

	always_comb begin
		case (tidx_q)
			2'd0:    cordic_angle = FINE_W'(a0_mod_w) * FINE_W'(FINE_SCALE);
			2'd1:    cordic_angle = FINE_W'(a1_mod_w) * FINE_W'(FINE_SCALE);
			2'd2:    cordic_angle = FINE_W'(d_q) * FINE_W'(FINE_SCALE);
			default: cordic_angle = (FINE_W'(d_q) * FINE_W'(FINE_SCALE)) >> 1;
		endcase
	end

	assign cordic_start = (state_q == ST_TRIG) && !launch_q;
	assign div_start    = (state_q == ST_DIV) && !launch_q;
	assign sqrt_start   = (state_q == ST_SQRT) && !launch_q;
	assign div_num      = {sq_q, 16'b0};
	assign div_den      = cq_q;
	assign t2x3_w       = 22'(t2_q) + {1'b0, t2_q, 1'b0};
	assign sqrt_op      = {SQRT_OP_W'(22'(4 * 65536) + t2x3_w)} << 16;

	// unit-circle factors of the four points, y negated when counter-clockwise
	always_comb begin
		fac[0] = 20'(c0_q);
		fac[1] = 20'(s0_q);
		fac[2] = 20'(c0_q) - m_q[0];
		fac[3] = 20'(s0_q) + m_q[1];
		fac[4] = 20'(c1_q) + m_q[2];
		fac[5] = 20'(s1_q) - m_q[3];
		fac[6] = 20'(c1_q);
		fac[7] = 20'(s1_q);
		if (ccw_q) begin
			fac[1] = -fac[1];
			fac[3] = -fac[3];
			fac[5] = -fac[5];
			fac[7] = -fac[7];
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MULSQ: begin
				mul_a = (sub_q == 4'd0) ? $signed({8'b0, sh_q}) : $signed({8'b0, ch_q});
				mul_b = mul_a;
			end
			ST_MULA: begin
				mul_a = $signed({8'b0, sd_q});
				mul_b = $signed({6'b0, root_q - SQRT_W'(TRIG_ONE)});
			end
			ST_DIV3: begin
				mul_a = $signed({4'b0, v_q});
				mul_b = 25'(DIV3_MAGIC);
			end
			ST_MULF: begin
				mul_b = $signed({5'b0, alpha_q});
				case (sub_q[1:0])
					2'd0:    mul_a = 25'(s0_q);
					2'd1:    mul_a = 25'(c0_q);
					2'd2:    mul_a = 25'(s1_q);
					default: mul_a = 25'(c1_q);
				endcase
			end
			ST_PLACE: begin
				mul_a = sub_q[0] ? $signed({2'b0, ry_q}) : $signed({2'b0, rx_q});
				mul_b = 25'(fac[sub_q[2:0]]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 50'(mul_a) * 50'(mul_b);
	end

	// rounding of arm terms and point placement with saturation
	assign m_w   = 20'((prod_q + 50'sd32768) >>> 16);
	assign rr_w  = 34'((prod_q + 50'sd32768) >>> 16);
	assign sum_w = 35'(rr_w) + (sub_q[0] ? 35'(cx_q) : 35'(cy_q));

	always_comb begin
		if (sum_w > 35'sd8388607)
			sat_w = 24'sh7fffff;
		else if (sum_w < -35'sd8388608)
			sat_w = 24'sh800000;
		else
			sat_w = sum_w[COORD_W-1:0];
	end

	assign seg_free = !seg_valid_q || seg_ready;

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			tidx_q      <= '0;
			sub_q       <= '0;
			n_q         <= '0;
			first_q     <= 1'b0;
			seg_valid_q <= 1'b0;
		end else begin
			// output register: loaded from the out state, cleared when taken
			if ((state_q == ST_OUT) && seg_free)
				seg_valid_q <= 1'b1;
			else if (seg_ready)
				seg_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (arc_valid) begin
						n_q     <= '0;
						first_q <= (s_wrap_w != bnd_w - 16'(QUARTER));
						if (span_w != '0)
							state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					first_q  <= 1'b0;
					tidx_q   <= '0;
					launch_q <= 1'b0;
					state_q  <= ST_TRIG;
				end
				ST_TRIG: begin
					if (!launch_q) begin
						launch_q <= 1'b1;
					end else if (cordic_done) begin
						launch_q <= 1'b0;
						tidx_q   <= tidx_q + 2'd1;
						if (tidx_q == 2'd3) begin
							sub_q   <= '0;
							state_q <= ST_MULSQ;
						end
					end
				end
				ST_MULSQ: begin
					sub_q <= sub_q + 4'd1;
					if (sub_q == 4'd2) begin
						launch_q <= 1'b0;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!launch_q) begin
						launch_q <= 1'b1;
					end else if (div_done) begin
						launch_q <= 1'b0;
						state_q  <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (!launch_q) begin
						launch_q <= 1'b1;
					end else if (sqrt_done) begin
						sub_q   <= '0;
						state_q <= ST_MULA;
					end
				end
				ST_MULA: begin
					if (sub_q == 4'd1) begin
						sub_q   <= '0;
						state_q <= ST_DIV3;
					end else begin
						sub_q <= sub_q + 4'd1;
					end
				end
				ST_DIV3: begin
					if (sub_q == 4'd1) begin
						sub_q   <= '0;
						state_q <= ST_MULF;
					end else begin
						sub_q <= sub_q + 4'd1;
					end
				end
				ST_MULF: begin
					if (sub_q == 4'd4) begin
						sub_q   <= '0;
						state_q <= ST_PLACE;
					end else begin
						sub_q <= sub_q + 4'd1;
					end
				end
				ST_PLACE: begin
					sub_q <= sub_q + 4'd1;
					if (sub_q == 4'd8)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (seg_free) begin
						n_q     <= n_q + 3'd1;
						state_q <= last_q ? ST_IDLE : ST_SETUP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cx_q   <= arc.center_x;
				cy_q   <= arc.center_y;
				rx_q   <= arc.radius_x;
				ry_q   <= arc.radius_y;
				ccw_q  <= arc.counter_clockwise;
				id_q   <= arc.first_segment_id;
				prev_q <= s_wrap_w;
				e_q    <= s_wrap_w + 16'(span_w);
				bnd_q  <= bnd_w;
			end
			ST_SETUP: begin
				a0_q   <= prev_q;
				a1_q   <= a1_w;
				d_q    <= 13'(a1_w - prev_q);
				last_q <= last_w;
				prev_q <= a1_w;
			end
			ST_TRIG: begin
				if (launch_q && cordic_done) begin
					case (tidx_q)
						2'd0: begin
							c0_q <= cordic_cos;
							s0_q <= cordic_sin;
						end
						2'd1: begin
							c1_q <= cordic_cos;
							s1_q <= cordic_sin;
						end
						2'd2: begin
							sd_q <= (cordic_sin < 0) ? 17'd0 : cordic_sin[16:0];
						end
						default: begin
							ch_q <= (cordic_cos < 18'sd1) ? 17'd1 : cordic_cos[16:0];
							sh_q <= (cordic_sin < 0) ? 17'd0 : cordic_sin[16:0];
						end
					endcase
				end
			end
			ST_MULSQ: begin
				if (sub_q == 4'd1)
					sq_q <= prod_q[DIV_DEN_W-1:0];
				if (sub_q == 4'd2)
					cq_q <= prod_q[DIV_DEN_W-1:0];
			end
			ST_DIV: begin
				if (launch_q && div_done)
					t2_q <= div_quo;
			end
			ST_SQRT: begin
				if (launch_q && sqrt_done)
					root_q <= (sqrt_root < SQRT_W'(TRIG_ONE)) ? SQRT_W'(TRIG_ONE) : sqrt_root;
			end
			ST_MULA: begin
				if (sub_q == 4'd1)
					v_q <= 21'((prod_q + 50'sd98304) >>> 16);
			end
			// divide by three as a reciprocal multiply
			ST_DIV3: begin
				if (sub_q == 4'd1)
					alpha_q <= DIV_Q_W'(prod_q >>> DIV3_SHIFT);
			end
			ST_MULF: begin
				if (sub_q != 4'd0)
					m_q[2'(sub_q - 4'd1)] <= m_w;
			end
			ST_PLACE: begin
				if (sub_q != 4'd0)
					pt_q[3'(sub_q - 4'd1)] <= sat_w;
			end
			ST_OUT: begin
				if (seg_free) begin
					seg_q.start_x    <= pt_q[0];
					seg_q.start_y    <= pt_q[1];
					seg_q.ctrl1_x    <= pt_q[2];
					seg_q.ctrl1_y    <= pt_q[3];
					seg_q.ctrl2_x    <= pt_q[4];
					seg_q.ctrl2_y    <= pt_q[5];
					seg_q.end_x      <= pt_q[6];
					seg_q.end_y      <= pt_q[7];
					seg_q.segment_id <= id_q + 16'(n_q);
					seg_q.last_piece <= last_q;
				end
			end
			default: begin
				cx_q <= cx_q;
			end
		endcase
	end

	assign arc_ready = (state_q == ST_IDLE);
	assign seg_valid = seg_valid_q;
	assign seg       = seg_q;

endmodule

>>> dv/tb_top.sv
// Self-checking bench for the elliptic arc to cubic Bezier converter.
// Depends on eac_pkg and the elliptic_arc_to_cubic_bezier top level.
`timescale 1ns / 1ps

module tb_top;
	import eac_pkg::*;

	localparam int  LIMIT_CYCLES = 2000000;
	localparam int  DRAIN_CYCLES = 1000;
	localparam int  RAND_ARCS    = 150;
	localparam int  QUIET_TAIL   = 20;
	localparam longint LQ        = 90 * 64;
	localparam longint LFULL     = 4 * LQ;
	localparam longint LFQ       = 90 * 65536;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     arc_valid = 1'b0;
	logic     arc_ready;
	arc_req_t arc = '0;
	logic     seg_valid;
	logic     seg_ready = 1'b0;
	seg_res_t seg;

	arc_req_t arc_queue[$];
	seg_res_t seg_expected[$];
	bit       failed = 1'b0;
	int       idle_in = 0;
	int       idle_out = 0;
	longint   cycles = 0;

	longint atan_tab[18] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
		29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

	elliptic_arc_to_cubic_bezier u_dut (
		.clk(clk), .arst_n(arst_n),
		.arc_valid(arc_valid), .arc_ready(arc_ready), .arc(arc),
		.seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint rnd16(longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// quadrant-folded cordic sine and cosine in q16
	task automatic sin_cos(input longint f, output longint c, output longint s);
		longint x, y, z, dx, dy, cc, ss, q;
		x = 652032875;
		y = 0;
		f = f % (4 * LFQ);
		q = f / LFQ;
		z = f % LFQ;
		for (int i = 0; i < 18; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - atan_tab[i];
			end else begin
				x = x + dx; y = y - dy; z = z + atan_tab[i];
			end
		end
		cc = clamp((x + 8192) >>> 14, 0, 65536);
		ss = clamp((y + 8192) >>> 14, 0, 65536);
		case (q)
			0: begin c = cc; s = ss; end
			1: begin c = -ss; s = cc; end
			2: begin c = -cc; s = -ss; end
			default: begin c = ss; s = -cc; end
		endcase
	endtask

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint fine_angle(longint a);
		return (a % LFULL) * 1024;
	endfunction

	function automatic logic signed [COORD_W-1:0] place_coord(longint ctr, longint rad,
			longint factor);
		return COORD_W'(clamp(ctr + rnd16(rad * factor), -8388608, 8388607));
	endfunction

	// split the arc into quarter pieces and queue one bezier per piece
	task automatic predict_segments(input arc_req_t a);
		longint p0[5], p1[5];
		longint s, span, e, b, prev, cx, cy, rx, ry, ym, d;
		longint c0, s0, c1, s1, cd, sd, ch, sh, alpha;
		longint unsigned t2, root;
		int n;
		seg_res_t r;
		cx = longint'(a.center_x);
		cy = longint'(a.center_y);
		rx = longint'({1'b0, a.radius_x});
		ry = longint'({1'b0, a.radius_y});
		s = longint'(a.start_angle) % LFULL;
		span = longint'(a.span_angle);
		ym = a.counter_clockwise ? -1 : 1;
		n = 0;
		if (span > LFULL) span = LFULL;
		if (span != 0) begin
			e = s + span;
			b = (s / LQ + 1) * LQ;
			if (b - s < LQ) begin
				prev = b < e ? b : e;
				p0[n] = s; p1[n] = prev; n++;
			end else begin
				prev = s;
			end
			while (e - prev >= LQ && n < 5) begin
				p0[n] = prev; p1[n] = prev + LQ; n++;
				prev = prev + LQ;
			end
			if (e > prev && n < 5) begin
				p0[n] = prev; p1[n] = e; n++;
			end
		end
		for (int k = 0; k < n; k++) begin
			d = p1[k] - p0[k];
			sin_cos(fine_angle(p0[k]), c0, s0);
			sin_cos(fine_angle(p1[k]), c1, s1);
			sin_cos(fine_angle(d), cd, sd);
			sin_cos(fine_angle(d) / 2, ch, sh);
			if (ch < 1) ch = 1;
			if (sd < 0) sd = 0;
			t2 = (longint'(sh * sh) << 16) / longint'(ch * ch);
			root = int_sqrt((262144 + 3 * t2) * 65536);
			if (root < 65536) root = 65536;
			alpha = longint'((longint'(sd) * (root - 65536) + 98304) / 196608);
			r.start_x = place_coord(cx, rx, c0);
			r.start_y = place_coord(cy, ry, ym * s0);
			r.ctrl1_x = place_coord(cx, rx, c0 - rnd16(s0 * alpha));
			r.ctrl1_y = place_coord(cy, ry, ym * (s0 + rnd16(c0 * alpha)));
			r.ctrl2_x = place_coord(cx, rx, c1 + rnd16(s1 * alpha));
			r.ctrl2_y = place_coord(cy, ry, ym * (s1 - rnd16(c1 * alpha)));
			r.end_x = place_coord(cx, rx, c1);
			r.end_y = place_coord(cy, ry, ym * s1);
			r.segment_id = a.first_segment_id + 16'(k);
			r.last_piece = (k == n - 1);
			seg_expected = {seg_expected, r};
		end
	endtask

	function automatic arc_req_t make_arc(longint cx, longint cy, longint rx, longint ry,
			int st, int sp, bit ccw, int id);
		arc_req_t a;
		a.center_x = COORD_W'(cx);
		a.center_y = COORD_W'(cy);
		a.radius_x = RAD_W'(rx);
		a.radius_y = RAD_W'(ry);
		a.start_angle = 16'(st);
		a.span_angle = 15'(sp);
		a.counter_clockwise = ccw;
		a.first_segment_id = 16'(id);
		return a;
	endfunction

	// append one arc to the pending requests
	function automatic void queue_arc(arc_req_t a);
		arc_queue = {arc_queue, a};
	endfunction

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			failed = 1'b1;
		end
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (arc_valid && arc_ready)
				predict_segments(arc);
			if (!(arc_valid && !arc_ready)) begin
				if (idle_in > 0) begin
					idle_in--;
					arc_valid <= 1'b0;
				end else if (arc_queue.size() > 0) begin
					if (arc_queue.size() > QUIET_TAIL && $urandom_range(0, 6) == 0) begin
						idle_in = $urandom_range(1, 6) - 1;
						arc_valid <= 1'b0;
					end else begin
						arc <= arc_queue.pop_front();
						arc_valid <= 1'b1;
					end
				end else begin
					arc_valid <= 1'b0;
				end
			end
		end
	end

	// segment monitor and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (seg_valid && seg_ready) begin
				if (seg_expected.size() == 0) begin
					$error("segment %0d arrived with none expected", seg.segment_id);
					failed = 1'b1;
				end else begin
					seg_res_t x;
					x = seg_expected.pop_front();
					check_field("start_x", x.start_x, seg.start_x);
					check_field("start_y", x.start_y, seg.start_y);
					check_field("ctrl1_x", x.ctrl1_x, seg.ctrl1_x);
					check_field("ctrl1_y", x.ctrl1_y, seg.ctrl1_y);
					check_field("ctrl2_x", x.ctrl2_x, seg.ctrl2_x);
					check_field("ctrl2_y", x.ctrl2_y, seg.ctrl2_y);
					check_field("end_x", x.end_x, seg.end_x);
					check_field("end_y", x.end_y, seg.end_y);
					check_field("segment_id", x.segment_id, seg.segment_id);
					check_field("last_piece", x.last_piece, seg.last_piece);
				end
			end
			if (idle_out > 0) begin
				idle_out--;
				seg_ready <= 1'b0;
			end else if (arc_queue.size() > QUIET_TAIL && $urandom_range(0, 6) == 0) begin
				idle_out = $urandom_range(1, 6) - 1;
				seg_ready <= 1'b0;
			end else begin
				seg_ready <= 1'b1;
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		int sp, st;
		longint rx, ry;
		// directed arcs: extremes, boundaries, short spans, wrap of the segment number
		queue_arc(make_arc(0, 0, 25600, 12800, 0, 0, 0, 1));
		queue_arc(make_arc(0, 0, 25600, 12800, 0, 5760, 0, 2));
		queue_arc(make_arc(1000, -1000, 25600, 25600, 5760, 23040, 1, 10));
		queue_arc(make_arc(0, 0, 8388607, 8388607, 100, 23040, 0, 65534));
		queue_arc(make_arc(8388607, 8388607, 8388607, 8388607, 1000, 23040, 1, 65535));
		queue_arc(make_arc(-8388608, -8388608, 8388607, 8388607, 3000, 23040, 0, 7));
		queue_arc(make_arc(-8388608, 8388607, 0, 0, 65535, 32767, 1, 0));
		queue_arc(make_arc(500, 500, 2560, 5120, 200, 300, 0, 20));
		queue_arc(make_arc(500, 500, 2560, 5120, 200, 1, 1, 21));
		queue_arc(make_arc(0, 0, 2560, 2560, 5759, 2, 0, 22));
		queue_arc(make_arc(0, 0, 2560, 2560, 17280, 5760, 1, 23));
		queue_arc(make_arc(0, 0, 2560, 2560, 23039, 23040, 0, 24));
		queue_arc(make_arc(0, 0, 2560, 2560, 46080, 11520, 1, 25));
		queue_arc(make_arc(0, 0, 8388607, 0, 1234, 20000, 0, 26));
		queue_arc(make_arc(0, 0, 0, 8388607, 4321, 23041, 1, 27));
		queue_arc(make_arc(0, 0, 2560, 2560, 11520, 23039, 0, 28));
		for (int i = 0; i < RAND_ARCS; i++) begin
			case ($urandom_range(0, 3))
				0: sp = $urandom_range(1, 5760);
				1: sp = $urandom_range(1, 23040);
				2: sp = $urandom_range(0, 32767);
				default: sp = 5760 * $urandom_range(1, 4);
			endcase
			st = ($urandom_range(0, 4) == 0) ? 5760 * $urandom_range(0, 11) :
				$urandom_range(0, 65535);
			rx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) : $urandom & 23'h7fffff;
			ry = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) : $urandom & 23'h7fffff;
			queue_arc(make_arc($signed(24'($urandom)), $signed(24'($urandom)), rx, ry,
				st, sp, 1'($urandom_range(0, 1)), $urandom_range(0, 65535)));
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (arc_queue.size() > 0 || arc_valid) @(posedge clk);
		while (seg_expected.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && seg_expected.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
